FILE: hw/rtl/rbsi_pkg.sv
package rbsi_pkg;

  // Fixed-point format and face match window (LSB)
  localparam int FRAC_BITS      = 16;
  localparam int FACE_TOLERANCE = 1;

  localparam int W    = 32;   // field width
  localparam int NAX  = 3;    // axes
  localparam int DW   = W + 1;           // corner - origin difference
  localparam int PW   = DW + W;          // full product width

  localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] SAT_MIN = -PW'(64'sd2147483648);

  typedef enum logic [2:0] {
    REG_NEAR_X = 3'd0,
    REG_NEAR_Y = 3'd1,
    REG_NEAR_Z = 3'd2,
    REG_FAR_X  = 3'd3,
    REG_FAR_Y  = 3'd4,
    REG_FAR_Z  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FACE_NONE   = 3'd0,
    FACE_NEAR_X = 3'd1,
    FACE_NEAR_Y = 3'd2,
    FACE_NEAR_Z = 3'd3,
    FACE_FAR_X  = 3'd4,
    FACE_FAR_Y  = 3'd5,
    FACE_FAR_Z  = 3'd6
  } face_t;

  // Drop fraction bits (floor) and clamp to the signed 32-bit range.
  function automatic logic signed [W-1:0] qsat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    sh = p >>> FRAC_BITS;
    if (sh > SAT_MAX) begin
      qsat = SAT_MAX[W-1:0];
    end else if (sh < SAT_MIN) begin
      qsat = SAT_MIN[W-1:0];
    end else begin
      qsat = sh[W-1:0];
    end
  endfunction

  // Clamp a 33-bit sum to 32 bits.
  function automatic logic signed [W-1:0] sat33(input logic signed [W:0] s);
    if (s[W] != s[W-1]) begin
      sat33 = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat33 = s[W-1:0];
    end
  endfunction

  function automatic logic face_match(input logic signed [W-1:0] p,
                                      input logic signed [W-1:0] plane);
    logic signed [W+1:0] d;
    logic signed [W+1:0] tol;
    d   = {{2{p[W-1]}}, p} - {{2{plane[W-1]}}, plane};
    tol = (W+2)'(FACE_TOLERANCE);
    face_match = (d <= tol) && (d >= -tol);
  endfunction

endpackage

FILE: hw/rtl/ray_box_slab_intersect_core.sv
// Ray versus axis-aligned box slab test, signed fixed point, eight-stage pipeline.
// An accepted input beat passes through stages 1 to 7 and the output register to the out_ port.
// Throughput: one ray per cycle; the whole pipe advances on one enable, so a stalled
// output beat holds every stage and in_ready drops in the same cycle.
// Reset (rst_n low, synchronous) clears all stage valid bits and the box corners to 0.
// The config port is always ready; writes beyond the register list are dropped.
module ray_box_slab_intersect_core (
  input  logic                clk,
  input  logic                rst_n,
  // input ray channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_origin_x,
  input  logic signed [31:0]  in_origin_y,
  input  logic signed [31:0]  in_origin_z,
  input  logic signed [31:0]  in_dir_x,
  input  logic signed [31:0]  in_dir_y,
  input  logic signed [31:0]  in_dir_z,
  input  logic signed [31:0]  in_inv_dir_x,
  input  logic signed [31:0]  in_inv_dir_y,
  input  logic signed [31:0]  in_inv_dir_z,
  input  logic signed [31:0]  in_scope_low,
  input  logic signed [31:0]  in_scope_high,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic signed [31:0]  out_hit_distance,
  output logic [2:0]          out_face,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int W   = rbsi_pkg::W;
  localparam int NAX = rbsi_pkg::NAX;
  localparam int DW  = rbsi_pkg::DW;
  localparam int PW  = rbsi_pkg::PW;
  localparam int NST = 7;  // internal stages ahead of the output register

  // ---------------------------------------------------------------------------
  // Box corners
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] near_r [NAX];
  logic signed [W-1:0] far_r  [NAX];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAX; i++) begin
        near_r[i] <= '0;
        far_r[i]  <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        rbsi_pkg::REG_NEAR_X: near_r[0] <= cfg_data;
        rbsi_pkg::REG_NEAR_Y: near_r[1] <= cfg_data;
        rbsi_pkg::REG_NEAR_Z: near_r[2] <= cfg_data;
        rbsi_pkg::REG_FAR_X:  far_r[0]  <= cfg_data;
        rbsi_pkg::REG_FAR_Y:  far_r[1]  <= cfg_data;
        rbsi_pkg::REG_FAR_Z:  far_r[2]  <= cfg_data;
        default: ;  // drop writes beyond the list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one enable for all stages. A stage moves whenever the
  // output register is empty or its beat is taken this cycle.
  // ---------------------------------------------------------------------------
  logic           adv;
  logic [NST-1:0] vld_r;
  logic           out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  assign out_valid = out_valid_r;

  // Unpack the input beat per axis
  logic signed [W-1:0] in_org [NAX];
  logic signed [W-1:0] in_dir [NAX];
  logic signed [W-1:0] in_inv [NAX];

  always_comb begin
    in_org[0] = in_origin_x;  in_org[1] = in_origin_y;  in_org[2] = in_origin_z;
    in_dir[0] = in_dir_x;     in_dir[1] = in_dir_y;     in_dir[2] = in_dir_z;
    in_inv[0] = in_inv_dir_x; in_inv[1] = in_inv_dir_y; in_inv[2] = in_inv_dir_z;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: corner - origin differences (exact, 33 bits). On an axis with a
  // negative reciprocal the far corner gives the entry slab.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] s1_ent_nxt [NAX];
  logic signed [DW-1:0] s1_lv_nxt  [NAX];
  logic signed [DW-1:0] s1_ent_r   [NAX];
  logic signed [DW-1:0] s1_lv_r    [NAX];
  logic signed [W-1:0]  s1_inv_r   [NAX];
  logic signed [W-1:0]  s1_org_r   [NAX];
  logic signed [W-1:0]  s1_dir_r   [NAX];
  logic signed [W-1:0]  s1_lo_r, s1_hi_r;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      logic signed [DW-1:0] dn;
      logic signed [DW-1:0] df;
      dn = {near_r[i][W-1], near_r[i]} - {in_org[i][W-1], in_org[i]};
      df = {far_r[i][W-1],  far_r[i]}  - {in_org[i][W-1], in_org[i]};
      s1_ent_nxt[i] = in_inv[i][W-1] ? df : dn;
      s1_lv_nxt[i]  = in_inv[i][W-1] ? dn : df;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: full-width slab products
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] s2_ent_r [NAX];
  logic signed [PW-1:0] s2_lv_r  [NAX];
  logic signed [W-1:0]  s2_org_r [NAX];
  logic signed [W-1:0]  s2_dir_r [NAX];
  logic signed [W-1:0]  s2_lo_r, s2_hi_r;

  // ---------------------------------------------------------------------------
  // Stage 3: floor-shift and saturate to entry/exit distances
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] s3_ent_r [NAX];
  logic signed [W-1:0] s3_lv_r  [NAX];
  logic signed [W-1:0] s3_org_r [NAX];
  logic signed [W-1:0] s3_dir_r [NAX];
  logic signed [W-1:0] s3_lo_r, s3_hi_r;

  // ---------------------------------------------------------------------------
  // Stage 4: fold the y slab into the x slab
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] s4_tmin_nxt, s4_tmax_nxt;
  logic                s4_miss_nxt;
  logic signed [W-1:0] s4_tmin_r, s4_tmax_r;
  logic                s4_miss_r;
  logic signed [W-1:0] s4_ent_z_r, s4_lv_z_r;
  logic signed [W-1:0] s4_org_r [NAX];
  logic signed [W-1:0] s4_dir_r [NAX];
  logic signed [W-1:0] s4_lo_r, s4_hi_r;

  always_comb begin
    s4_miss_nxt = (s3_ent_r[0] > s3_lv_r[1]) || (s3_lv_r[0] < s3_ent_r[1]);
    s4_tmin_nxt = (s3_ent_r[1] > s3_ent_r[0]) ? s3_ent_r[1] : s3_ent_r[0];
    s4_tmax_nxt = (s3_lv_r[1]  < s3_lv_r[0])  ? s3_lv_r[1]  : s3_lv_r[0];
  end

  // ---------------------------------------------------------------------------
  // Stage 5: fold z, pick entry or exit distance, check the window
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] s5_t_nxt;
  logic                s5_hit_nxt;
  logic signed [W-1:0] s5_t_r;
  logic                s5_hit_r;
  logic signed [W-1:0] s5_org_r [NAX];
  logic signed [W-1:0] s5_dir_r [NAX];

  always_comb begin
    logic                miss_z;
    logic signed [W-1:0] tmin;
    logic signed [W-1:0] tmax;
    miss_z = (s4_tmin_r > s4_lv_z_r) || (s4_tmax_r < s4_ent_z_r);
    tmin   = (s4_ent_z_r > s4_tmin_r) ? s4_ent_z_r : s4_tmin_r;
    tmax   = (s4_lv_z_r  < s4_tmax_r) ? s4_lv_z_r  : s4_tmax_r;
    // starting inside the box: report the exit distance
    s5_t_nxt   = (tmin < 0 && tmax > 0) ? tmax : tmin;
    s5_hit_nxt = !(s4_miss_r || miss_z || (s5_t_nxt < s4_lo_r) || (s5_t_nxt > s4_hi_r));
  end

  // ---------------------------------------------------------------------------
  // Stage 6: dir * t products for the hit point
  // ---------------------------------------------------------------------------
  logic signed [2*W-1:0] s6_prod_r [NAX];
  logic signed [W-1:0]   s6_org_r  [NAX];
  logic signed [W-1:0]   s6_t_r;
  logic                  s6_hit_r;

  // ---------------------------------------------------------------------------
  // Stage 7: hit point = sat(origin + sat(dir * t))
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] s7_pt_nxt [NAX];
  logic signed [W-1:0] s7_pt_r   [NAX];
  logic signed [W-1:0] s7_t_r;
  logic                s7_hit_r;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      logic signed [W-1:0] q;
      logic signed [W:0]   s;
      q = rbsi_pkg::qsat(PW'(s6_prod_r[i]));
      s = {s6_org_r[i][W-1], s6_org_r[i]} + {q[W-1], q};
      s7_pt_nxt[i] = rbsi_pkg::sat33(s);
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: face search in priority order, zero the fields on a miss
  // ---------------------------------------------------------------------------
  rbsi_pkg::face_t     face_nxt;
  logic                out_hit_r;
  logic signed [W-1:0] out_dist_r;
  logic [2:0]          out_face_r;

  always_comb begin
    if (rbsi_pkg::face_match(s7_pt_r[0], near_r[0])) begin
      face_nxt = rbsi_pkg::FACE_NEAR_X;
    end else if (rbsi_pkg::face_match(s7_pt_r[1], near_r[1])) begin
      face_nxt = rbsi_pkg::FACE_NEAR_Y;
    end else if (rbsi_pkg::face_match(s7_pt_r[2], near_r[2])) begin
      face_nxt = rbsi_pkg::FACE_NEAR_Z;
    end else if (rbsi_pkg::face_match(s7_pt_r[0], far_r[0])) begin
      face_nxt = rbsi_pkg::FACE_FAR_X;
    end else if (rbsi_pkg::face_match(s7_pt_r[1], far_r[1])) begin
      face_nxt = rbsi_pkg::FACE_FAR_Y;
    end else if (rbsi_pkg::face_match(s7_pt_r[2], far_r[2])) begin
      face_nxt = rbsi_pkg::FACE_FAR_Z;
    end else begin
      face_nxt = rbsi_pkg::FACE_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers: no reset, all held by the common enable
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      for (int i = 0; i < NAX; i++) begin
        s1_ent_r[i] <= s1_ent_nxt[i];
        s1_lv_r[i]  <= s1_lv_nxt[i];
        s1_inv_r[i] <= in_inv[i];
        s1_org_r[i] <= in_org[i];
        s1_dir_r[i] <= in_dir[i];
      end
      s1_lo_r <= in_scope_low;
      s1_hi_r <= in_scope_high;
      // stage 2
      for (int i = 0; i < NAX; i++) begin
        s2_ent_r[i] <= s1_ent_r[i] * s1_inv_r[i];
        s2_lv_r[i]  <= s1_lv_r[i] * s1_inv_r[i];
        s2_org_r[i] <= s1_org_r[i];
        s2_dir_r[i] <= s1_dir_r[i];
      end
      s2_lo_r <= s1_lo_r;
      s2_hi_r <= s1_hi_r;
      // stage 3
      for (int i = 0; i < NAX; i++) begin
        s3_ent_r[i] <= rbsi_pkg::qsat(s2_ent_r[i]);
        s3_lv_r[i]  <= rbsi_pkg::qsat(s2_lv_r[i]);
        s3_org_r[i] <= s2_org_r[i];
        s3_dir_r[i] <= s2_dir_r[i];
      end
      s3_lo_r <= s2_lo_r;
      s3_hi_r <= s2_hi_r;
      // stage 4
      s4_tmin_r  <= s4_tmin_nxt;
      s4_tmax_r  <= s4_tmax_nxt;
      s4_miss_r  <= s4_miss_nxt;
      s4_ent_z_r <= s3_ent_r[2];
      s4_lv_z_r  <= s3_lv_r[2];
      for (int i = 0; i < NAX; i++) begin
        s4_org_r[i] <= s3_org_r[i];
        s4_dir_r[i] <= s3_dir_r[i];
      end
      s4_lo_r <= s3_lo_r;
      s4_hi_r <= s3_hi_r;
      // stage 5
      s5_t_r   <= s5_t_nxt;
      s5_hit_r <= s5_hit_nxt;
      for (int i = 0; i < NAX; i++) begin
        s5_org_r[i] <= s4_org_r[i];
        s5_dir_r[i] <= s4_dir_r[i];
      end
      // stage 6
      for (int i = 0; i < NAX; i++) begin
        s6_prod_r[i] <= s5_dir_r[i] * s5_t_r;
        s6_org_r[i]  <= s5_org_r[i];
      end
      s6_t_r   <= s5_t_r;
      s6_hit_r <= s5_hit_r;
      // stage 7
      for (int i = 0; i < NAX; i++) begin
        s7_pt_r[i] <= s7_pt_nxt[i];
      end
      s7_t_r   <= s6_t_r;
      s7_hit_r <= s6_hit_r;
      // output
      out_hit_r  <= s7_hit_r;
      out_dist_r <= s7_hit_r ? s7_t_r : '0;
      out_face_r <= s7_hit_r ? 3'(face_nxt) : 3'(rbsi_pkg::FACE_NONE);
    end
  end

  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_dist_r;
  assign out_face         = out_face_r;

endmodule

FILE: hw/rtl/rbsi_checker.sv
module rbsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_hit_distance,
  input logic [2:0]  out_face
);

  // A waiting result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_hit_distance) && $stable(out_face))
    else $error("result beat changed while stalled");

  // A miss carries zero distance and no face.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_distance == 32'd0 && out_face == 3'd0)
    else $error("miss beat with nonzero fields");

  // Face codes stop at the far z face.
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_face <= 3'd6)
    else $error("face code out of range");

  // Input side stalls exactly when a result beat is held.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> in_ready == !(out_valid && !out_ready))
    else $error("in_ready does not follow output stall");

endmodule

bind ray_box_slab_intersect_core rbsi_checker u_rbsi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_hit          (out_hit),
  .out_hit_distance (out_hit_distance),
  .out_face         (out_face)
);
